@@ rtl/lpm_pkg.sv @@
// Package for the auto-pan LFO: item types, register indexes and fixed-point constants.
package lpm_pkg;

    localparam int SINE_DEPTH_DEFAULT = 256;

    localparam int TIME_W   = 48;
    localparam int PERIOD_W = 32;
    localparam int PHASE_W  = 16;
    localparam int PAN_W    = 17;
    localparam int HEAD_W   = 2;
    localparam int DIV_STEPS = TIME_W + PHASE_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_ON     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTION_ON   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_POINT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_SHAPE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PAN_BASE    = 3'd6;

    localparam logic [1:0] SHAPE_SINE     = 2'd0;
    localparam logic [1:0] SHAPE_SQUARE   = 2'd1;
    localparam logic [1:0] SHAPE_TRIANGLE = 2'd2;

    localparam logic [PAN_W-1:0] PAN_BASE_RESET = 17'd32768;
    localparam logic [PAN_W-1:0] PAN_MAX        = 17'd65536;

    typedef struct packed {
        logic [HEAD_W-1:0] head_index;
        logic [TIME_W-1:0] play_time;
    } in_item_t;

    typedef struct packed {
        logic [HEAD_W-1:0] dest_head;
        logic [PAN_W-1:0]  final_pan;
    } out_item_t;

    typedef struct packed {
        logic                head_on;
        logic                motion_on;
        logic [PERIOD_W-1:0] period_duration;
        logic [PHASE_W-1:0]  start_point;
        logic [PAN_W-1:0]    width;
        logic [1:0]          wave_shape;
        logic [PAN_W-1:0]    pan_base;
    } cfg_t;

endpackage

@@ rtl/lpm_divider.sv @@
// Bit-serial pipelined long division giving the fractional part of play_time / period.
module lpm_divider
    import lpm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_vld,
    input  logic [HEAD_W-1:0]   in_head,
    input  logic [TIME_W-1:0]   in_time,
    input  logic [PERIOD_W-1:0] period,
    output logic                out_vld,
    output logic [HEAD_W-1:0]   out_head,
    output logic [PHASE_W-1:0]  out_frac
);

    typedef struct packed {
        logic [HEAD_W-1:0]   head;
        logic [PERIOD_W-1:0] rem;
        logic [TIME_W-1:0]   dvd;
        logic [PHASE_W-1:0]  quo;
    } div_stage_t;

    logic       vld_reg [DIV_STEPS];
    div_stage_t stg_reg [DIV_STEPS];

    genvar s;
    generate
        for (s = 0; s < DIV_STEPS; s++) begin : g_step
            div_stage_t          prev;
            logic                prev_vld;
            logic [PERIOD_W:0]   trial;
            logic                ge;
            div_stage_t          stg_next;

            if (s == 0) begin : g_first
                assign prev_vld = in_vld;
                assign prev     = '{head: in_head, rem: '0, dvd: in_time, quo: '0};
            end else begin : g_rest
                assign prev_vld = vld_reg[s-1];
                assign prev     = stg_reg[s-1];
            end

            // Low dividend bits run out after the time bits; zeros shift in.
            always_comb
            begin
                trial = {prev.rem, prev.dvd[TIME_W-1]};
                ge    = (trial >= {1'b0, period});
                stg_next.head = prev.head;
                stg_next.rem  = ge ? PERIOD_W'(trial - {1'b0, period}) : trial[PERIOD_W-1:0];
                stg_next.dvd  = {prev.dvd[TIME_W-2:0], 1'b0};
                stg_next.quo  = {prev.quo[PHASE_W-2:0], ge};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[s] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[s] <= prev_vld;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    stg_reg[s] <= stg_next;
                end
            end
        end
    endgenerate

    assign out_vld  = vld_reg[DIV_STEPS-1];
    assign out_head = stg_reg[DIV_STEPS-1].head;
    assign out_frac = stg_reg[DIV_STEPS-1].quo;

endmodule

@@ rtl/lpm_wave.sv @@
// Phase offset, waveform lookup, depth multiply and clamped pan output stages.
module lpm_wave
    import lpm_pkg::*;
#(
    parameter int SineDepth = SINE_DEPTH_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  cfg_t               cfg,
    input  logic               in_vld,
    input  logic [HEAD_W-1:0]  in_head,
    input  logic [PHASE_W-1:0] in_frac,
    output logic               out_vld,
    output out_item_t          out_item
);

    localparam int IdxW = $clog2(SineDepth + 1);
    localparam longint Q30_ONE     = 64'sd1073741824;
    localparam longint Q30_HALF_PI = 64'sd1686629713;
    localparam logic [IdxW-1:0] DEPTH_W = IdxW'(SineDepth);

    // Divides a series term by (2n)(2n+1), the next pair of factorial factors.
    function automatic longint pair_div(input longint term, input int n);
        case (n)
            1:       return term / 64'sd6;
            2:       return term / 64'sd20;
            3:       return term / 64'sd42;
            4:       return term / 64'sd72;
            5:       return term / 64'sd110;
            6:       return term / 64'sd156;
            7:       return term / 64'sd210;
            8:       return term / 64'sd272;
            9:       return term / 64'sd342;
            10:      return term / 64'sd420;
            11:      return term / 64'sd506;
            12:      return term / 64'sd600;
            13:      return term / 64'sd702;
            14:      return term / 64'sd812;
            15:      return term / 64'sd930;
            16:      return term / 64'sd1056;
            17:      return term / 64'sd1190;
            18:      return term / 64'sd1332;
            default: return term / 64'sd1482;
        endcase
    endfunction

    function automatic int sine_entry(input int k);
        longint x;
        longint term;
        longint sum;
        x    = (Q30_HALF_PI * longint'(k)) / SineDepth;
        term = x;
        sum  = x;
        for (int n = 1; n < 20; n++)
        begin
            if (term != 0)
            begin
                term = ((term * x) / Q30_ONE) * x / Q30_ONE;
                term = pair_div(term, n);
                if (n % 2 == 1)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
        end
        if (sum < 0)
            sum = 0;
        if (sum > Q30_ONE)
            sum = Q30_ONE;
        return int'((sum * 32768 + Q30_ONE / 2) / Q30_ONE);
    endfunction

    logic [PHASE_W:0] sine_rom [SineDepth + 1];

    genvar k;
    generate
        for (k = 0; k <= SineDepth; k++) begin : g_rom
            localparam int SINE_VAL = sine_entry(k);
            assign sine_rom[k] = (PHASE_W + 1)'(SINE_VAL);
        end
    endgenerate

    // Phase stage.
    logic               ph_vld_reg;
    logic [HEAD_W-1:0]  ph_head_reg;
    logic [PHASE_W-1:0] ph_reg;
    logic [PHASE_W-1:0] ph_next;

    assign ph_next = (cfg.period_duration == '0) ? '0 : PHASE_W'(in_frac + cfg.start_point);

    // Waveform stage.
    logic                     wv_vld_reg;
    logic [HEAD_W-1:0]        wv_head_reg;
    logic signed [PHASE_W:0]  wv_reg;
    logic signed [PHASE_W:0]  wv_next;
    logic [13+IdxW:0]         idx_prod;
    logic [IdxW-1:0]          idx;
    logic [IdxW-1:0]          rom_addr;
    logic [PHASE_W:0]         sine_mag;
    logic signed [PHASE_W+1:0] tri_val;
    logic signed [PHASE_W+1:0] ph_s;

    always_comb
    begin
        idx_prod = (14 + IdxW)'(ph_reg[13:0]) * (14 + IdxW)'(DEPTH_W);
        idx      = idx_prod[14 +: IdxW];
        rom_addr = ph_reg[14] ? IdxW'(DEPTH_W - idx) : idx;
        sine_mag = sine_rom[rom_addr];
        ph_s     = signed'({2'b00, ph_reg});
        if (ph_reg < 16'd16384)
            tri_val = ph_s <<< 1;
        else if (ph_reg < 16'd49152)
            tri_val = 18'sd65536 - (ph_s <<< 1);
        else
            tri_val = (ph_s - 18'sd65536) <<< 1;
        case (cfg.wave_shape)
            SHAPE_SINE:
                wv_next = ph_reg[15] ? -signed'(sine_mag) : signed'(sine_mag);
            SHAPE_SQUARE:
                wv_next = ph_reg[15] ? -17'sd32768 : 17'sd32768;
            SHAPE_TRIANGLE:
                wv_next = tri_val[PHASE_W:0];
            default:
                wv_next = '0;
        endcase
    end

    // Multiply stage.
    logic                     mul_vld_reg;
    logic [HEAD_W-1:0]        mul_head_reg;
    logic signed [34:0]       prod_reg;
    logic signed [34:0]       prod_next;

    assign prod_next = 35'(signed'({1'b0, cfg.width})) * 35'(wv_reg);

    // Pan stage; the arithmetic shift floors like the model's rounding.
    logic signed [20:0] pan_sum;
    logic [PAN_W-1:0]   pan_next;

    always_comb
    begin
        pan_sum = 21'(signed'({2'b00, cfg.pan_base, 1'b0})) + 21'(prod_reg >>> 15);
        if (pan_sum < 0)
            pan_next = '0;
        else if (pan_sum > 21'(signed'({1'b0, PAN_MAX})))
            pan_next = PAN_MAX;
        else
            pan_next = pan_sum[PAN_W-1:0];
    end

    logic      out_vld_reg;
    out_item_t out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_vld_reg  <= 1'b0;
            wv_vld_reg  <= 1'b0;
            mul_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            ph_vld_reg  <= in_vld;
            wv_vld_reg  <= ph_vld_reg;
            mul_vld_reg <= wv_vld_reg;
            out_vld_reg <= mul_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ph_head_reg  <= in_head;
            ph_reg       <= ph_next;
            wv_head_reg  <= ph_head_reg;
            wv_reg       <= wv_next;
            mul_head_reg <= wv_head_reg;
            prod_reg     <= prod_next;
            out_item_reg <= '{dest_head: mul_head_reg, final_pan: pan_next};
        end
    end

    assign out_vld  = out_vld_reg;
    assign out_item = out_item_reg;

endmodule

@@ rtl/lfo_pan_modulator.sv @@
// Auto-pan LFO: one clamped pan value for each enabled play-time beat.
//
// Input beats (in_valid/in_stall, in_data) carry a head tag and a 48-bit play
// time in 1/65536 s. When head_on and motion_on are both set, each beat
// yields one output beat (out_valid/out_stall, out_data) with the head tag and
// the pan in Q1.16; otherwise the beat is taken and nothing comes out.
// Load registers via cfg_wr_en/cfg_index/cfg_data only while idle (not enforced).
//
// The time is divided by the period in a long division with one bit per stage,
// followed by phase, waveform, multiply and pan stages.
// One beat is accepted every cycle while out_stall is low.
// When a waiting output beat is stalled, the whole pipeline holds and
// in_stall goes high; nothing is dropped or repeated.
// Reset clears all valid bits and loads the register reset values
// (pan_base 0.5, everything else 0); there is no clearing pass.
module lfo_pan_modulator
    import lpm_pkg::*;
#(
    parameter int SineDepth = SINE_DEPTH_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{head_on: 1'b0, motion_on: 1'b0, period_duration: '0,
                         start_point: '0, width: '0, wave_shape: '0,
                         pan_base: PAN_BASE_RESET};
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_HEAD_ON:     cfg_reg.head_on         <= cfg_data[0];
                CFG_MOTION_ON:   cfg_reg.motion_on       <= cfg_data[0];
                CFG_PERIOD:      cfg_reg.period_duration <= cfg_data;
                CFG_START_POINT: cfg_reg.start_point     <= cfg_data[PHASE_W-1:0];
                CFG_WIDTH:       cfg_reg.width           <= cfg_data[PAN_W-1:0];
                CFG_WAVE_SHAPE:  cfg_reg.wave_shape      <= cfg_data[1:0];
                CFG_PAN_BASE:    cfg_reg.pan_base        <= cfg_data[PAN_W-1:0];
                default:         ;
            endcase
        end
    end

    logic               en;
    logic               div_vld;
    logic [HEAD_W-1:0]  div_head;
    logic [PHASE_W-1:0] div_frac;

    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    lpm_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (in_valid && cfg_reg.head_on && cfg_reg.motion_on),
        .in_head  (in_data.head_index),
        .in_time  (in_data.play_time),
        .period   (cfg_reg.period_duration),
        .out_vld  (div_vld),
        .out_head (div_head),
        .out_frac (div_frac)
    );

    lpm_wave #(
        .SineDepth (SineDepth)
    ) u_wave (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .cfg      (cfg_reg),
        .in_vld   (div_vld),
        .in_head  (div_head),
        .in_frac  (div_frac),
        .out_vld  (out_valid),
        .out_item (out_data)
    );

endmodule

@@ rtl/lpm_checker.sv @@
// Port-level checker for the auto-pan LFO and its bind to the top level.
module lpm_checker
    import lpm_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled output beat changed");

    a_pan_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.final_pan <= PAN_MAX)
        else $error("pan beyond 1.0");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input taken while output is blocked");

    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with no output waiting");

endmodule

bind lfo_pan_modulator lpm_checker u_lpm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

@@ tb/lpm_checker.sv @@
// Checker for the auto-pan LFO: watches both channels, predicts each pan beat and compares.
module lpm_tb_checker
    import lpm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  in_item_t              in_data,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  out_item_t             out_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    pending,
    output int                    errors
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = SINE_DEPTH_DEFAULT;
    localparam longint Q30_ONE = 64'sd1073741824;
    localparam longint Q30_HALF_PI = 64'sd1686629713;

    int        sine_lut [0:DEPTH];
    cfg_t      regs;
    out_item_t pan_queue [$];

    // Quarter-wave sine table, built with the same integer Taylor series as the RTL table.
    initial
    begin
        longint x;
        longint term;
        longint sum;
        for (int k = 0; k <= DEPTH; k++)
        begin
            x = (Q30_HALF_PI * k) / DEPTH;
            term = x;
            sum = x;
            for (int n = 1; n < 20 && term != 0; n++)
            begin
                term = ((term * x) / Q30_ONE) * x / Q30_ONE;
                term = term / ((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    sum -= term;
                else
                    sum += term;
            end
            if (sum < 0)
                sum = 0;
            if (sum > Q30_ONE)
                sum = Q30_ONE;
            sine_lut[k] = int'((sum * 32768 + Q30_ONE / 2) / Q30_ONE);
        end
    end

    function automatic int wave_value(logic [PHASE_W-1:0] ph, logic [1:0] shape);
        int idx;
        int v;
        int p;
        p = int'(ph);
        case (shape)
            SHAPE_SINE:
            begin
                idx = (int'(ph[13:0]) * DEPTH) >>> 14;
                v = ph[14] ? sine_lut[DEPTH - idx] : sine_lut[idx];
                return ph[15] ? -v : v;
            end
            SHAPE_SQUARE:
                return (p < 32768) ? 32768 : -32768;
            SHAPE_TRIANGLE:
            begin
                if (p < 16384)
                    return 2 * p;
                if (p < 49152)
                    return 32768 - 2 * (p - 16384);
                return -32768 + 2 * (p - 49152);
            end
            default:
                return 0;
        endcase
    endfunction

    function automatic logic [PAN_W-1:0] pan_for_time(logic [TIME_W-1:0] t);
        longint unsigned rem;
        longint unsigned frac;
        logic [PHASE_W-1:0] ph;
        longint prod;
        longint scaled;
        longint pan;
        ph = '0;
        if (regs.period_duration != 0)
        begin
            rem = 64'(t) % 64'(regs.period_duration);
            frac = (rem << 16) / 64'(regs.period_duration);
            ph = PHASE_W'(frac + 64'(regs.start_point));
        end
        prod = longint'(regs.width) * longint'(wave_value(ph, regs.wave_shape));
        if (prod >= 0)
            scaled = prod / 32768;
        else
            scaled = -((-prod + 32767) / 32768);
        pan = 2 * longint'(regs.pan_base) + scaled;
        if (pan < 0)
            pan = 0;
        if (pan > 65536)
            pan = 65536;
        return PAN_W'(pan);
    endfunction

    // Everything is sampled on the falling edge, where handshake signals are settled.
    always @(negedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            regs = '0;
            regs.pan_base = PAN_BASE_RESET;
            pan_queue.delete();
            pending = 0;
            errors = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_HEAD_ON:     regs.head_on = cfg_data[0];
                    CFG_MOTION_ON:   regs.motion_on = cfg_data[0];
                    CFG_PERIOD:      regs.period_duration = cfg_data;
                    CFG_START_POINT: regs.start_point = cfg_data[PHASE_W-1:0];
                    CFG_WIDTH:       regs.width = cfg_data[PAN_W-1:0];
                    CFG_WAVE_SHAPE:  regs.wave_shape = cfg_data[1:0];
                    CFG_PAN_BASE:    regs.pan_base = cfg_data[PAN_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall && regs.head_on && regs.motion_on)
            begin
                want.dest_head = in_data.head_index;
                want.final_pan = pan_for_time(in_data.play_time);
                pan_queue.push_back(want);
            end
            if (out_valid && !out_stall)
            begin
                if (pan_queue.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected pan beat: head %0d pan %0d",
                                 out_data.dest_head, out_data.final_pan);
                end
                else
                begin
                    want = pan_queue.pop_front();
                    if (out_data.dest_head !== want.dest_head
                        || out_data.final_pan !== want.final_pan)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("pan mismatch: expected head %0d pan %0d, got head %0d pan %0d",
                                     want.dest_head, want.final_pan,
                                     out_data.dest_head, out_data.final_pan);
                    end
                end
            end
            pending = pan_queue.size();
        end
    end

endmodule

@@ tb/tb.sv @@
// Testbench top for the auto-pan LFO: clock, reset, stimulus, register setup and verdict.
module tb
    import lpm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 68;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TARGET_ITEMS = 1050;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_item_t             out_data;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    pending;
    int                    errors;
    int                    cycles;
    bit                    fast_sender;
    bit                    fast_receiver;

    lfo_pan_modulator uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    lpm_tb_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .pending(pending), .errors(errors)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("FAIL lfo_pan_modulator");
                $finish;
            end
        end
    end

    // Receiver: may hold out_stall high at random before taking each beat, never when fast_receiver is set.
    initial
    begin
        int g;
        bit took;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            g = fast_receiver ? 0 : $urandom_range(0, 11);
            if (g > 0)
            begin
                out_stall <= 1'b1;
                repeat (g) @(posedge clk);
                out_stall <= 1'b0;
            end
            do
            begin
                @(negedge clk);
                took = out_valid && !out_stall;
                @(posedge clk);
            end while (!took);
        end
    end

    // Leaves the write enable high; the caller lowers it after the last write.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic load_regs(bit hon, bit mon, logic [31:0] period, logic [15:0] start,
                             logic [31:0] wid, logic [1:0] shape, logic [31:0] base);
        write_reg(CFG_HEAD_ON, 32'(hon));
        write_reg(CFG_MOTION_ON, 32'(mon));
        write_reg(CFG_PERIOD, period);
        write_reg(CFG_START_POINT, 32'(start));
        write_reg(CFG_WIDTH, wid);
        write_reg(CFG_WAVE_SHAPE, 32'(shape));
        write_reg(CFG_PAN_BASE, base);
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_NO_REG, $urandom);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending != 0)
            @(posedge clk);
    endtask

    // Items that make no result may still be in flight, so wait out the pipeline too.
    task automatic wait_idle();
        wait_drained();
        repeat (LATENCY + 12) @(posedge clk);
    endtask

    task automatic send_time(logic [HEAD_W-1:0] head, logic [TIME_W-1:0] t);
        int g;
        bit took;
        g = fast_sender ? 0 : $urandom_range(0, 11);
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data.head_index <= head;
        in_data.play_time <= t;
        do
        begin
            @(negedge clk);
            took = !in_stall;
            @(posedge clk);
        end while (!took);
    endtask

    function automatic logic [TIME_W-1:0] random_time();
        if ($urandom_range(0, 1) == 0)
            return TIME_W'({$urandom, $urandom});
        return TIME_W'($urandom_range(0, 400000));
    endfunction

    function automatic logic [31:0] pick_level();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'd65536;
            2: return 32'd131071;
            default: return 32'($urandom_range(0, 65536));
        endcase
    endfunction

    initial
    begin
        logic [TIME_W-1:0] directed_times [6];
        logic [31:0] period;
        int sent;
        int phase_no;
        int n;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        fast_sender = 1'b0;
        fast_receiver = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_times = '{48'd0, 48'd16384, 48'd32768, 48'd49152, 48'd65535, '1};
        for (int s = 0; s < 4; s++)
        begin
            load_regs(1'b1, 1'b1, 32'd65536, 16'd0, 32'd65536, 2'(s), 32'(PAN_BASE_RESET));
            for (int k = 0; k < 6; k++)
                send_time(2'(k), directed_times[k]);
            in_valid <= 1'b0;
            wait_idle();
        end

        sent = 24;
        phase_no = 0;
        while (sent < TARGET_ITEMS)
        begin
            case ($urandom_range(0, 4))
                0: period = 32'd0;
                1: period = 32'd1;
                2: period = 32'hFFFF_FFFF;
                3: period = $urandom_range(1, 70000);
                default: period = $urandom;
            endcase
            if (phase_no == 2)
                period = 32'd0;
            load_regs(phase_no != 0 && $urandom_range(0, 9) != 0,
                      phase_no != 1 && $urandom_range(0, 9) != 0,
                      period,
                      ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom),
                      pick_level(), 2'($urandom_range(0, 3)), pick_level());
            fast_sender = ($urandom_range(0, 3) == 0);
            fast_receiver = ($urandom_range(0, 3) == 0);
            n = $urandom_range(40, 80);
            for (int k = 0; k < n; k++)
            begin
                if (phase_no == 3 && k == n / 2)
                begin
                    in_valid <= 1'b0;
                    wait_drained();
                end
                send_time(2'($urandom), random_time());
            end
            in_valid <= 1'b0;
            sent += n;
            phase_no++;
            wait_idle();
        end

        if (errors == 0 && pending == 0)
            $display("PASS lfo_pan_modulator");
        else
            $display("FAIL lfo_pan_modulator");
        $finish;
    end

endmodule
